### design/ric_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ric_pkg: shared definitions for the radix integer-to-digits converter
// Widths of the request and response fields, the radix limits and the
// digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package ric_pkg;

   localparam int unsigned ValueWidth = 64;
   localparam int unsigned RadixWidth = 6;
   localparam int unsigned DigitWidth = 6;
   localparam int unsigned CharWidth  = 7;
   localparam int unsigned CountWidth = 7;

   localparam logic [RadixWidth-1:0] RadixMin   = 6'd2;
   localparam logic [RadixWidth-1:0] RadixMax   = 6'd36;
   localparam logic [RadixWidth-1:0] RadixReset = 6'd10;

   localparam logic [CharWidth-1:0] AsciiZero   = 7'd48;
   // 'A' minus ten, so that digit ten maps to 'A'.
   localparam logic [CharWidth-1:0] AsciiLetter = 7'd55;

   typedef logic [ValueWidth-1:0] value_type;
   typedef logic [RadixWidth-1:0] radix_type;
   typedef logic [DigitWidth-1:0] digit_type;
   typedef logic [CharWidth-1:0]  char_type;
   typedef logic [CountWidth-1:0] count_type;

   // Maps a digit to its ASCII glyph; codes of 36 and above give '0'.
   function automatic char_type digit_ascii(input digit_type d);
      char_type c;
      if (d < 6'd10) begin
         c = AsciiZero + {1'b0, d};
      end else if (d < RadixMax) begin
         c = AsciiLetter + {1'b0, d};
      end else begin
         c = AsciiZero;
      end
      return c;
   endfunction

   // Keeps a radix write inside the supported range.
   function automatic radix_type clamp_radix(input radix_type r);
      radix_type c;
      if (r < RadixMin) begin
         c = RadixMin;
      end else if (r > RadixMax) begin
         c = RadixMax;
      end else begin
         c = r;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### design/radix_integer_to_digits_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radix_integer_to_digits_top: unsigned 64-bit integer to radix digit string
// Converts a value into ASCII digits ('0'-'9', 'A'-'Z') in a radix of 2..36.
//
// A request is taken at a rising edge with start high and busy low; req_value
// carries the integer. The block divides it repeatedly by the radix in one
// shared restoring divider and writes each remainder to the digit store as a
// digit. When it is through dividing, it reads the digit store back most
// significant digit first, one digit per cycle. Each response is shown on the
// rsp_ ports for exactly one cycle with rsp_strobe high; the receiver cannot
// stall it. rsp_digit_count gives the total digit count and rsp_last marks the
// least significant digit. Zero gives the single digit '0'.
// Per digit, the divider runs and its remainder is written to the store; the
// digits are then read back one by one through the registered store read and
// the response stage. Busy stays high until the last response is registered,
// so the next request can be taken at the edge that ends the last response.
// The user must write the radix register through csr_wr_en/csr_wr_data only
// while the block is idle; the block itself does not enforce this. Writes
// outside 2..36 are clamped. Reset (synchronous, active high) returns the
// radix to 10 and the block to idle.
// ----------------------------------------------------------------------------
module radix_integer_to_digits_top #(
   parameter int unsigned MAX_DIGIT_COUNT = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire ric_pkg::value_type req_value,
   output      logic               rsp_strobe,
   output      ric_pkg::char_type  rsp_digit_char,
   output      ric_pkg::count_type rsp_digit_count,
   output      logic               rsp_last,
   input  wire logic               csr_wr_en,
   input  wire ric_pkg::radix_type csr_wr_data
);
   import ric_pkg::*;

   localparam int unsigned AddrWidth = $clog2(MAX_DIGIT_COUNT);
   localparam int unsigned CntWidth  = $clog2(MAX_DIGIT_COUNT + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   radix_type             radix_ff, radix_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic [AddrWidth-1:0]  rd_addr_ff, rd_addr_in;
   logic                  rd_pending_ff, rd_pending_in;
   logic                  rd_last_ff, rd_last_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   char_type              rsp_char_ff, rsp_char_in;
   count_type             rsp_count_ff, rsp_count_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  div_start;
   value_type             div_dividend;
   logic                  div_done;
   value_type             div_quotient;
   digit_type             div_remainder;
   logic                  store_wr_en;
   logic                  store_rd_en;
   digit_type             store_rd_data;
   logic [CntWidth-1:0]   count_next;

   assign busy   = (state_ff != ST_IDLE) || rd_pending_ff;
   assign accept = start && !busy;

   ric_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (radix_ff),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   ric_ram #(
      .WIDTH (DigitWidth),
      .DEPTH (MAX_DIGIT_COUNT)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (count_ff[AddrWidth-1:0]),
      .wr_data (div_remainder),
      .rd_en   (store_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (store_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      radix_in      = radix_ff;
      count_in      = count_ff;
      rd_addr_in    = rd_addr_ff;
      rd_pending_in = 1'b0;
      rd_last_in    = 1'b0;
      div_start     = 1'b0;
      div_dividend  = req_value;
      store_wr_en   = 1'b0;
      store_rd_en   = 1'b0;
      count_next    = count_ff + 1'b1;

      // Response stage: registers the store read data in the cycle after the read.
      rsp_strobe_in = rd_pending_ff;
      rsp_char_in   = digit_ascii(store_rd_data);
      rsp_count_in  = CountWidth'(count_ff);
      rsp_last_in   = rd_last_ff;

      if (csr_wr_en) begin
         radix_in = clamp_radix(csr_wr_data);
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               div_start = 1'b1;
               count_in  = '0;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               store_wr_en = 1'b1;
               count_in    = count_next;
               // Stop when the quotient reaches zero or the store is full.
               if (div_quotient == '0 ||
                   count_next == CntWidth'(MAX_DIGIT_COUNT)) begin
                  rd_addr_in = count_ff[AddrWidth-1:0];
                  state_in   = ST_EMIT;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = div_quotient;
               end
            end
         end
         ST_EMIT: begin
            store_rd_en   = 1'b1;
            rd_pending_in = 1'b1;
            rd_last_in    = (rd_addr_ff == '0);
            if (rd_addr_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               rd_addr_in = rd_addr_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         radix_ff      <= RadixReset;
         count_ff      <= '0;
         rd_pending_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         radix_ff      <= radix_in;
         count_ff      <= count_in;
         rd_pending_ff <= rd_pending_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rd_addr_ff   <= rd_addr_in;
      rd_last_ff   <= rd_last_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_digit_char  = rsp_char_ff;
   assign rsp_digit_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   // A response always carries a legal glyph and a nonzero digit count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_digit_char >= 7'd48 && rsp_digit_char <= 7'd57) ||
                      (rsp_digit_char >= 7'd65 && rsp_digit_char <= 7'd90)))
      else $error("response glyph out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_digit_count != '0))
      else $error("response with zero digit count");

   // The final digit closes the burst of responses.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("response after the last digit");

   // An accepted request keeps the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after a request");

   // The radix register never leaves the supported range.
   assert property (@(posedge clock) disable iff (reset)
      (radix_ff >= RadixMin) && (radix_ff <= RadixMax))
      else $error("radix register out of range");

endmodule
`default_nettype wire

### design/ric_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ric_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ric_ram #(
   parameter int unsigned WIDTH = 6,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

### design/ric_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ric_divider: iterative 64-bit by radix divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ric_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire ric_pkg::value_type dividend,
   input  wire ric_pkg::radix_type divisor,
   output      logic              done,
   output      ric_pkg::value_type quotient,
   output      ric_pkg::digit_type remainder
);
   import ric_pkg::*;

   localparam int unsigned StepWidth = $clog2(ValueWidth);

   value_type              quo_ff, quo_in;
   digit_type              rem_ff, rem_in;
   logic [StepWidth-1:0]   step_ff, step_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DigitWidth:0]    partial;
   logic [DigitWidth:0]    diff;
   logic                   fits;

   always_comb begin
      partial = {rem_ff, quo_ff[ValueWidth-1]};
      diff    = partial - {1'b0, divisor};
      fits    = partial >= {1'b0, divisor};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[ValueWidth-2:0], fits};
         rem_in  = fits ? diff[DigitWidth-1:0] : partial[DigitWidth-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == StepWidth'(ValueWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         quo_ff  <= quo_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire
